// ===== sv/playfair_pair_decrypt_assert.svh =====
// Assertion macros for the Playfair pair decrypt block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef PLAYFAIR_PAIR_DECRYPT_ASSERT_SVH
`define PLAYFAIR_PAIR_DECRYPT_ASSERT_SVH

// Condition that must hold at every edge out of reset
`define PFD_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define PFD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pfd_pkg.sv =====
// Shared types, character constants and helpers for the Playfair pair decrypt block.
// No dependencies.
`default_nettype none

package pfd_pkg;

	localparam int LETTERS  = 26;
	localparam int LETTER_W = 5;

	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_Z     = 8'h5A;
	localparam logic [7:0] CHAR_W     = 8'h57;
	localparam logic [7:0] CHAR_X     = 8'h58;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LZ    = 8'h7A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	localparam logic [LETTER_W-1:0] OMIT_IDX = LETTER_W'(22);

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_PAIR   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NOT_IN_SQUARE = 2'd1,
		ST_NOT_READY     = 2'd2
	} status_t;

	function automatic logic is_upper(input logic [7:0] ch);
		return (ch >= CHAR_A) && (ch <= CHAR_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] ch);
		return (ch >= CHAR_LA) && (ch <= CHAR_LZ);
	endfunction

	// Letter index of an upper-case byte; meaningless for other bytes
	function automatic logic [LETTER_W-1:0] letter_index(input logic [7:0] ch);
		logic [7:0] diff;
		diff = ch - CHAR_A;
		return diff[LETTER_W-1:0];
	endfunction

	// Byte for a plaintext letter, X shown as a space
	function automatic logic [7:0] letter_out(input logic [LETTER_W-1:0] idx);
		logic [7:0] ch;
		ch = CHAR_A + {3'b000, idx};
		return (ch == CHAR_X) ? CHAR_SPACE : ch;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pfd_if.sv =====
// Request and result channel interfaces for the Playfair pair decrypt block.
// No dependencies.
`default_nettype none

interface pfd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] key_char;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic       second_present;

	modport source (output valid, command, key_char, first_char, second_char,
		second_present, input ready);
	modport sink (input valid, command, key_char, first_char, second_char,
		second_present, output ready);
endinterface

interface pfd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_first;
	logic [7:0] plain_second;
	logic [1:0] status;

	modport source (output valid, plain_first, plain_second, status, input ready);
	modport sink (input valid, plain_first, plain_second, status, output ready);
endinterface

`default_nettype wire

// ===== sv/pfd_ram2r.sv =====
// Synchronous memory with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module pfd_ram2r #(
	parameter int DEPTH = 26,
	parameter int WIDTH = 6
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== sv/playfair_pair_decrypt.sv =====
// Playfair pair decryption over a 5x5 square without W. Each request carries a
// command: a key byte, finish square (after acceptance the alphabet is walked one
// letter per cycle, each unused letter placed), decrypt pair, or clear square.
// A pair reads the letter-position memory at both letters, then the square memory
// at both result cells; the next request can be taken while a pair's result loads.
// Only a pair gives a result, with status 0 ok, 1 letter not in the square, 2 square
// not finished. A held result does not stop new requests until the next pair's
// result is due. No clearing pass after reset.
// Depends on pfd_pkg, pfd_if and pfd_ram2r.
`default_nettype none

module playfair_pair_decrypt
	import pfd_pkg::*;
#(
	parameter int SQUARE_SIDE = 5
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pfd_cmd_if.sink    cmd,
	pfd_res_if.source  res
);

	localparam int CELLS  = SQUARE_SIDE * SQUARE_SIDE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int RC_W   = $clog2(SQUARE_SIDE);
	localparam int POS_W  = 2 * RC_W;
	localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(SQUARE_SIDE);
	localparam logic [RC_W-1:0]   LAST_RC  = RC_W'(SQUARE_SIDE - 1);
	localparam logic [CNT_W-1:0]  CELLS_C  = CNT_W'(CELLS);
	localparam logic [LETTER_W-1:0] LAST_L = LETTER_W'(LETTERS - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FILL  = 4'b0010,
		S_LOOK  = 4'b0100,
		S_FETCH = 4'b1000
	} state_t;

	function automatic logic [RC_W-1:0] dec_wrap(input logic [RC_W-1:0] v);
		return (v == '0) ? LAST_RC : v - RC_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_of(input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] k);
		return ADDR_W'(r) * SIDE_A + ADDR_W'(k);
	endfunction

	state_t state_q, state_d, acc_state;
	logic [LETTERS-1:0]  used_q;
	logic [CNT_W-1:0]    fill_cnt_q;
	logic [RC_W-1:0]     fill_row_q, fill_col_q;
	logic                ready_q;
	logic [LETTER_W-1:0] walk_q;
	status_t             status_s1, status_s2;
	logic                res_valid_q;
	logic [7:0]          res_first_q, res_second_q;
	logic [1:0]          res_status_q;

	logic                slot_free, acc;
	cmd_t                command;
	logic [7:0]          key_up, c2;
	logic                try_place, place_ok;
	logic [LETTER_W-1:0] place_idx, idx1, idx2;
	logic                v1, v2, pair_acc;
	logic [POS_W-1:0]    pos_a, pos_b;
	logic [RC_W-1:0]     r1, k1, r2, k2;
	logic [ADDR_W-1:0]   o1, o2;
	logic [LETTER_W-1:0] sq_a, sq_b;

	// Handshake
	assign slot_free = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE) || ((state_q == S_FETCH) && slot_free);
	assign acc       = cmd.valid && cmd.ready;
	assign command   = cmd_t'(cmd.command);

	// Placement of one letter: from the key byte or from the finishing walk
	assign key_up = is_lower(cmd.key_char) ? cmd.key_char - CASE_DIFF : cmd.key_char;
	always_comb begin
		if (state_q == S_FILL) begin
			try_place = 1'b1;
			place_idx = walk_q;
		end else begin
			try_place = acc && (command == CMD_KEY) && is_upper(key_up);
			place_idx = letter_index(key_up);
		end
	end
	assign place_ok = try_place && (place_idx != OMIT_IDX) && !used_q[place_idx]
		&& (fill_cnt_q < CELLS_C);

	// Pair lookup: both letters must be placed
	assign c2       = cmd.second_present ? cmd.second_char : CHAR_Z;
	assign idx1     = letter_index(cmd.first_char);
	assign idx2     = letter_index(c2);
	assign v1       = is_upper(cmd.first_char) && (idx1 != OMIT_IDX) && used_q[idx1];
	assign v2       = is_upper(c2) && (idx2 != OMIT_IDX) && used_q[idx2];
	assign pair_acc = acc && (command == CMD_PAIR);

	pfd_ram2r #(
		.DEPTH (LETTERS),
		.WIDTH (POS_W)
	) u_pos_mem (
		.clk     (clk),
		.we      (place_ok),
		.waddr   (place_idx),
		.wdata   ({fill_row_q, fill_col_q}),
		.re      (pair_acc),
		.raddr_a (v1 ? idx1 : '0),
		.raddr_b (v2 ? idx2 : '0),
		.rdata_a (pos_a),
		.rdata_b (pos_b)
	);

	// Result cells from the two positions
	assign r1 = pos_a[POS_W-1:RC_W];
	assign k1 = pos_a[RC_W-1:0];
	assign r2 = pos_b[POS_W-1:RC_W];
	assign k2 = pos_b[RC_W-1:0];
	always_comb begin
		priority if (r1 == r2) begin
			o1 = cell_of(r1, dec_wrap(k1));
			o2 = cell_of(r2, dec_wrap(k2));
		end else if (k1 == k2) begin
			o1 = cell_of(dec_wrap(r1), k1);
			o2 = cell_of(dec_wrap(r2), k2);
		end else begin
			o1 = cell_of(r1, k2);
			o2 = cell_of(r2, k1);
		end
	end

	pfd_ram2r #(
		.DEPTH (CELLS),
		.WIDTH (LETTER_W)
	) u_square_mem (
		.clk     (clk),
		.we      (place_ok),
		.waddr   (fill_cnt_q[ADDR_W-1:0]),
		.wdata   (place_idx),
		.re      (state_q == S_LOOK),
		.raddr_a (o1),
		.raddr_b (o2),
		.rdata_a (sq_a),
		.rdata_b (sq_b)
	);

	// Next state for an accepted request
	always_comb begin
		unique case (command)
			CMD_FINISH: acc_state = S_FILL;
			CMD_PAIR:   acc_state = S_LOOK;
			CMD_KEY,
			CMD_CLEAR:  acc_state = S_IDLE;
			default:    acc_state = S_IDLE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) state_d = acc_state;
			end
			S_FILL: begin
				if (walk_q == LAST_L) state_d = S_IDLE;
			end
			S_LOOK: begin
				state_d = S_FETCH;
			end
			S_FETCH: begin
				if (slot_free) state_d = acc ? acc_state : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state: square fill, used letters, ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			fill_cnt_q <= '0;
			fill_row_q <= '0;
			fill_col_q <= '0;
			ready_q    <= 1'b0;
			walk_q     <= '0;
		end else begin
			state_q <= state_d;
			priority if (acc && (command == CMD_CLEAR)) begin
				used_q     <= '0;
				fill_cnt_q <= '0;
				fill_row_q <= '0;
				fill_col_q <= '0;
				ready_q    <= 1'b0;
			end else if (place_ok) begin
				used_q[place_idx] <= 1'b1;
				fill_cnt_q        <= fill_cnt_q + CNT_W'(1);
				if (fill_col_q == LAST_RC) begin
					fill_col_q <= '0;
					fill_row_q <= fill_row_q + RC_W'(1);
				end else begin
					fill_col_q <= fill_col_q + RC_W'(1);
				end
			end
			if (acc && (command == CMD_FINISH)) begin
				walk_q <= '0;
			end else if (state_q == S_FILL) begin
				walk_q <= walk_q + LETTER_W'(1);
				if (walk_q == LAST_L) ready_q <= 1'b1;
			end
		end
	end

	// Pair status travels with the memory reads
	always_ff @(posedge clk) begin
		if (pair_acc) begin
			if (!ready_q) status_s1 <= ST_NOT_READY;
			else if (!(v1 && v2)) status_s1 <= ST_NOT_IN_SQUARE;
			else status_s1 <= ST_OK;
		end
		if (state_q == S_LOOK) begin
			status_s2 <= status_s1;
		end
	end

	// Result register: load when the slot frees, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_FETCH) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FETCH) && slot_free) begin
			res_status_q <= status_s2;
			if (status_s2 == ST_OK) begin
				res_first_q  <= letter_out(sq_a);
				res_second_q <= letter_out(sq_b);
			end else begin
				res_first_q  <= '0;
				res_second_q <= '0;
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.plain_first  = res_first_q;
	assign res.plain_second = res_second_q;
	assign res.status       = res_status_q;

endmodule

`default_nettype wire

// ===== sv/pfd_checker.sv =====
// Port checker for the Playfair pair decrypt block, bound to the top level.
// Depends on pfd_pkg and playfair_pair_decrypt_assert.svh.
`default_nettype none

`include "playfair_pair_decrypt_assert.svh"

module pfd_checker
	import pfd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] plain_first,
	input wire logic [7:0] plain_second,
	input wire logic [1:0] status
);

	function automatic logic is_plain(input logic [7:0] ch);
		return (ch == CHAR_SPACE) ||
			(is_upper(ch) && (ch != CHAR_W) && (ch != CHAR_X));
	endfunction

	// Hold a waiting result unchanged
	`PFD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(plain_first) && $stable(plain_second) && $stable(status), "result changed while stalled")

	// Zero letters on any error
	`PFD_ASSERT_IMPLY(a_err_zero, res_valid && (status != ST_OK), (plain_first == 8'h00) && (plain_second == 8'h00), "error result carries letters")

	// Good pairs give square letters, X shown as space
	`PFD_ASSERT(a_ok_letters, !(res_valid && (status == ST_OK)) || (is_plain(plain_first) && is_plain(plain_second)), "bad plaintext letter")

endmodule

bind playfair_pair_decrypt pfd_checker u_pfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.plain_first  (res.plain_first),
	.plain_second (res.plain_second),
	.status       (res.status)
);

`default_nettype wire
